// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the match engine.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ACME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ACME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/acme_pkg.sv =====
// Types and constants shared by the match engine modules.
// No dependencies.
package acme_pkg;

  localparam int NODE_COUNT  = 4096;
  localparam int NODE_BITS   = 12;
  localparam int LINK_COUNT  = 8192;
  localparam int LINK_BITS   = 13;
  localparam int SYMBOL_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int HASH_SHIFT  = 17;
  localparam int HASH_BITS   = LINK_BITS + HASH_SHIFT;
  localparam logic [31:0] NODE_MULT = 32'd40503;
  localparam logic [47:0] SYM_MULT  = 48'd2654435761;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_LINK  = 2'd1,
    ACT_MATCH = 2'd2,
    ACT_QUERY = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_BOUND   = 2'd3
  } status_e;

  typedef struct packed {
    act_e                   act;
    logic [NODE_BITS-1:0]   node;
    logic [SYMBOL_BITS-1:0] sym;
    logic [NODE_BITS-1:0]   child;
    logic [NODE_BITS-1:0]   fail;
    logic [NODE_BITS-1:0]   parent;
    logic [COUNT_BITS-1:0]  count;
  } req_t;

  // Handshake between the request queue and the execution engine.
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_out_t;

  typedef struct packed {
    logic pop;
    logic clearing;
    logic idle;
  } back_stat_t;

  typedef struct packed {
    status_e                status;
    logic [NODE_BITS-1:0]   node;
    logic [SYMBOL_BITS-1:0] sym;
    logic [NODE_BITS-1:0]   parent;
    logic [COUNT_BITS-1:0]  count;
  } result_t;

endpackage

// ===== hw/rtl/acme_front.sv =====
// Front end: accepts requests and queues them.
// Depends on acme_pkg.
module acme_front import acme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_req_i,
  input  back_stat_t stat_i,
  output queue_out_t q_o
);

  localparam int PtrBits = $clog2(QUEUE_DEPTH);

  req_t                 buf_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]     fill_q, fill_d;
  logic                 push;

  // No request is taken while the child store is being cleared or the queue is full.
  assign in_stall_o = stat_i.clearing || (fill_q == (PtrBits+1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    fill_d = fill_q;
    if (push && !stat_i.pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!push && stat_i.pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (stat_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_req_i;
    end
  end

  assign q_o.valid = (fill_q != '0);
  assign q_o.req   = buf_q[rd_ptr_q];

endmodule

// ===== hw/rtl/acme_back.sv =====
// Execution engine: child store with hashed linear probing, node tables,
// fail-link walk and the result register. Depends on acme_pkg.
module acme_back import acme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  queue_out_t q_i,
  output back_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    res_o
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_HASH    = 9'b000000100,
    S_SLOT    = 9'b000001000,
    S_PRB_RD  = 9'b000010000,
    S_PRB_CMP = 9'b000100000,
    S_REC_RD  = 9'b001000000,
    S_REC     = 9'b010000000,
    S_OUT     = 9'b100000000
  } fsm_e;

  typedef struct packed {
    logic                   valid;
    logic [NODE_BITS-1:0]   node;
    logic [SYMBOL_BITS-1:0] sym;
    logic [NODE_BITS-1:0]   child;
  } link_t;

  fsm_e state_q, state_d;

  link_t                  link_mem [LINK_COUNT];
  logic [NODE_BITS-1:0]   fail_mem [NODE_COUNT];
  logic [SYMBOL_BITS-1:0] sym_mem  [NODE_COUNT];
  logic [NODE_BITS-1:0]   par_mem  [NODE_COUNT];
  logic [COUNT_BITS-1:0]  cnt_mem  [NODE_COUNT];

  link_t                  link_rd_q;
  logic [NODE_BITS-1:0]   fail_rd_q, par_rd_q;
  logic [SYMBOL_BITS-1:0] sym_rd_q;
  logic [COUNT_BITS-1:0]  cnt_rd_q;

  logic [LINK_BITS-1:0]   clr_q, clr_d;
  logic [LINK_BITS-1:0]   slot_q, slot_d;
  logic [LINK_BITS-1:0]   probes_q, probes_d;
  logic [NODE_BITS:0]     steps_q, steps_d;
  logic [NODE_BITS-1:0]   cur_q, cur_d;
  logic [NODE_BITS-1:0]   child_q, child_d;
  logic [NODE_BITS-1:0]   rec_q, rec_d;
  logic [SYMBOL_BITS-1:0] sym_q, sym_d;
  act_e                   act_q, act_d;
  logic [HASH_BITS-1:0]   pa_q, pa_d, pb_q, pb_d, hsum;
  result_t                pend_q, pend_d, res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  logic                   lk_we;
  logic [LINK_BITS-1:0]   lk_waddr;
  link_t                  lk_wdata;
  logic                   tb_we;
  logic                   pop;
  logic                   hit;

  assign hit  = link_rd_q.valid && (link_rd_q.node == cur_q) && (link_rd_q.sym == sym_q);
  assign hsum = pa_q + pb_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    slot_d   = slot_q;
    probes_d = probes_q;
    steps_d  = steps_q;
    cur_d    = cur_q;
    child_d  = child_q;
    rec_d    = rec_q;
    sym_d    = sym_q;
    act_d    = act_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    pend_d   = pend_q;
    lk_we    = 1'b0;
    lk_waddr = slot_q;
    lk_wdata = link_rd_q;
    tb_we    = 1'b0;
    pop      = 1'b0;
    res_d       = res_q;
    res_valid_d = res_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_q;
        lk_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LINK_BITS'(LINK_COUNT-1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_i.valid) begin
          pop     = 1'b1;
          act_d   = q_i.req.act;
          cur_d   = q_i.req.node;
          sym_d   = q_i.req.sym;
          child_d = q_i.req.child;
          rec_d   = q_i.req.node;
          steps_d = '0;
          case (q_i.req.act)
            ACT_WRITE: begin
              tb_we         = 1'b1;
              pend_d.status = ST_OK;
              pend_d.node   = q_i.req.node;
              pend_d.sym    = q_i.req.sym;
              pend_d.parent = q_i.req.parent;
              pend_d.count  = q_i.req.count;
              state_d       = S_OUT;
            end
            ACT_QUERY: state_d = S_REC_RD;
            default:   state_d = S_HASH;
          endcase
        end
      end
      S_HASH: begin
        pa_d    = HASH_BITS'({20'd0, cur_q} * NODE_MULT);
        pb_d    = HASH_BITS'({16'd0, sym_q} * SYM_MULT[31:0]);
        state_d = S_SLOT;
      end
      S_SLOT: begin
        slot_d   = hsum[LINK_BITS-1:0] ^ hsum[HASH_SHIFT +: LINK_BITS];
        probes_d = '0;
        state_d  = S_PRB_RD;
      end
      S_PRB_RD: state_d = S_PRB_CMP;
      S_PRB_CMP: begin
        if (act_q == ACT_LINK) begin
          if (hit || !link_rd_q.valid) begin
            lk_we          = 1'b1;
            lk_wdata.valid = 1'b1;
            lk_wdata.node  = cur_q;
            lk_wdata.sym   = sym_q;
            lk_wdata.child = child_q;
            pend_d         = '0;
            pend_d.status  = ST_OK;
            pend_d.node    = child_q;
            state_d        = S_OUT;
          end else if (probes_q == LINK_BITS'(LINK_COUNT-1)) begin
            pend_d        = '0;
            pend_d.status = ST_FULL;
            state_d       = S_OUT;
          end else begin
            slot_d   = slot_q + 1'b1;
            probes_d = probes_q + 1'b1;
            state_d  = S_PRB_RD;
          end
        end else begin
          if (hit) begin
            rec_d   = link_rd_q.child;
            state_d = S_REC_RD;
          end else if (!link_rd_q.valid || probes_q == LINK_BITS'(LINK_COUNT-1)) begin
            // The walk moves on: root miss, cycle bound, or follow the fail link.
            if (cur_q == '0) begin
              pend_d        = '0;
              pend_d.status = ST_NOMATCH;
              state_d       = S_OUT;
            end else if (steps_q == (NODE_BITS+1)'(NODE_COUNT)) begin
              pend_d        = '0;
              pend_d.status = ST_BOUND;
              state_d       = S_OUT;
            end else begin
              cur_d   = fail_rd_q;
              steps_d = steps_q + 1'b1;
              state_d = S_HASH;
            end
          end else begin
            slot_d   = slot_q + 1'b1;
            probes_d = probes_q + 1'b1;
            state_d  = S_PRB_RD;
          end
        end
      end
      S_REC_RD: state_d = S_REC;
      S_REC: begin
        pend_d.status = ST_OK;
        pend_d.node   = rec_q;
        pend_d.sym    = sym_rd_q;
        pend_d.parent = par_rd_q;
        pend_d.count  = cnt_rd_q;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!res_valid_q || !out_stall_i) begin
          res_d       = pend_q;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    probes_q <= probes_d;
    steps_q  <= steps_d;
    cur_q    <= cur_d;
    child_q  <= child_d;
    rec_q    <= rec_d;
    sym_q    <= sym_d;
    act_q    <= act_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    pend_q   <= pend_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    link_rd_q <= link_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      fail_mem[q_i.req.node] <= q_i.req.fail;
      sym_mem[q_i.req.node]  <= q_i.req.sym;
      par_mem[q_i.req.node]  <= q_i.req.parent;
      cnt_mem[q_i.req.node]  <= q_i.req.count;
    end
    fail_rd_q <= fail_mem[cur_q];
    sym_rd_q  <= sym_mem[rec_q];
    par_rd_q  <= par_mem[rec_q];
    cnt_rd_q  <= cnt_mem[rec_q];
  end

  assign stat_o.pop      = pop;
  assign stat_o.clearing = (state_q == S_CLEAR);
  assign stat_o.idle     = (state_q == S_IDLE);
  assign out_valid_o     = res_valid_q;
  assign res_o           = res_q;

endmodule

// ===== hw/rtl/aho_corasick_match_engine_unit.sv =====
// Aho-Corasick match engine. After reset the block clears its 8192-entry
// child store, one entry a cycle, and takes no request while it clears.
// Requests then enter a two-entry queue, so the input side keeps
// accepting, until the queue is full, while the engine works and while a
// result waits in the output register. A node write takes the request and
// writes the node tables together, then loads the result register; a
// query takes the request, reads the node record in S_REC_RD and S_REC,
// then loads the result register. A child-link add or a match step takes
// the request, hashes the (node, symbol) pair into a start slot in S_HASH
// and S_SLOT, and spends S_PRB_RD and S_PRB_CMP on every child-store slot
// probed, since each probe is one registered read of the child store
// followed by a compare; an add then loads the result register. A match
// repeats the hash and the probes for every fail link it follows, then
// reads the record of the matched node and loads the result register.
// A walk caught in a fail-link loop gives up after 4096 steps.
// Depends on acme_pkg, acme_front, acme_back and assert_macros.svh.
`include "assert_macros.svh"

module aho_corasick_match_engine_unit import acme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_action_i,
  input  logic [11:0] in_node_index_i,
  input  logic [15:0] in_symbol_i,
  input  logic [11:0] in_child_index_i,
  input  logic [11:0] in_fail_index_i,
  input  logic [11:0] in_parent_index_i,
  input  logic [31:0] in_count_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_status_o,
  output logic [11:0] out_result_node_o,
  output logic [15:0] out_node_symbol_o,
  output logic [11:0] out_node_parent_o,
  output logic [31:0] out_node_count_o
);

  req_t       in_req;
  queue_out_t queue;
  back_stat_t stat;
  result_t    res;

  // The action code is classified into its enum when the request is queued.
  assign in_req.act    = act_e'(in_action_i);
  assign in_req.node   = in_node_index_i;
  assign in_req.sym    = in_symbol_i;
  assign in_req.child  = in_child_index_i;
  assign in_req.fail   = in_fail_index_i;
  assign in_req.parent = in_parent_index_i;
  assign in_req.count  = in_count_value_i;

  acme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .stat_i     (stat),
    .q_o        (queue)
  );

  acme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (queue),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_status_o      = res.status;
  assign out_result_node_o = res.node;
  assign out_node_symbol_o = res.sym;
  assign out_node_parent_o = res.parent;
  assign out_node_count_o  = res.count;

  // The clearing pass must hold the input side off.
  `ACME_ASSERT(a_clear_stalls, stat.clearing |-> in_stall_o, "request taken during clear")
  // The engine only pops the queue from idle, and never an empty queue.
  `ACME_ASSERT(a_pop_legal, stat.pop |-> (stat.idle && queue.valid), "illegal queue pop")
  // After a pop the engine is busy with the request.
  `ACME_ASSERT_NEXT(a_pop_busy, stat.pop, !stat.idle, "engine idle after pop")
  // No result can exist before the child store is cleared.
  `ACME_ASSERT(a_no_result_in_clear, stat.clearing |-> !out_valid_o, "result during clear")

endmodule
